// File: sv/socm_pkg.sv
// ----------------------------------------------------------------------------
// socm_pkg
// Register indexes and the shared trim flag type for the segment octree child mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package socm_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_PLANE = 3;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_Z    = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_X      = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_Y      = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_Z      = 3'd5;
  localparam logic [IDX_W-1:0] REG_TRIM_START = 3'd6;
  localparam logic [IDX_W-1:0] REG_TRIM_END   = 3'd7;

  typedef struct packed {
    logic trim_start;
    logic trim_end;
  } trim_t;

endpackage

`default_nettype wire

// File: sv/segment_octree_child_mask.sv
// ----------------------------------------------------------------------------
// segment_octree_child_mask
// Marks the children of an octree node that a configured segment may cross.
// ----------------------------------------------------------------------------
// usage
//   the segment end points and the two trim flags are set over the apb port
//   while no transaction is in flight; a read returns the stored value
//   a node transaction is taken at a rising edge with start high and busy
//   low; busy never rises, so a node may be issued on every cycle
//   each node's result appears on visit_mask with done high for exactly one
//   cycle, once the node has passed the four register stages
//   throughput is one node per cycle; the datapath has four register
//   stages: differences, 33x33 cross products, 67-bit sign adds, mask build
//   results come out in issue order; the receiver cannot stall, so no
//   buffering is held back
//   reset clears the configuration registers to zero and drops every transaction in flight
//   coordinates are signed fixed point; all plane-side tests are exact cross products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_octree_child_mask #(
  parameter int COORD_WIDTH = 32,
  localparam int DW = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AW = $clog2(8 * (DW / 8))
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [AW-1:0]                 paddr,
  input  wire logic [DW-1:0]                 pwdata,
  output logic      [DW-1:0]                 prdata,
  output logic                               pready,
  // node transaction
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] lower_x,
  input  wire logic signed [COORD_WIDTH-1:0] lower_y,
  input  wire logic signed [COORD_WIDTH-1:0] lower_z,
  input  wire logic signed [COORD_WIDTH-1:0] center_x,
  input  wire logic signed [COORD_WIDTH-1:0] center_y,
  input  wire logic signed [COORD_WIDTH-1:0] center_z,
  input  wire logic signed [COORD_WIDTH-1:0] upper_x,
  input  wire logic signed [COORD_WIDTH-1:0] upper_y,
  input  wire logic signed [COORD_WIDTH-1:0] upper_z,
  input  wire logic [7:0]                    child_present,
  // result
  output logic                               done,
  output logic [7:0]                         visit_mask
);
  import socm_pkg::*;

  logic [2:0][COORD_WIDTH-1:0]      p1, p2;
  logic [2:0][2:0][COORD_WIDTH-1:0] bnd;
  trim_t                            trim;

  // fully pipelined, never refuses a node
  assign busy = 1'b0;

  // plane index outer, axis inner
  assign bnd = {{upper_z, upper_y, upper_x},
                {center_z, center_y, center_x},
                {lower_z, lower_y, lower_x}};

  socm_regs #(.COORD_WIDTH(COORD_WIDTH)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .p1      (p1),
    .p2      (p2),
    .trim    (trim)
  );

  socm_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .bnd       (bnd),
    .present   (child_present),
    .p1        (p1),
    .p2        (p2),
    .trim      (trim),
    .out_valid (done),
    .out_mask  (visit_mask)
  );

endmodule

`default_nettype wire

// File: sv/socm_regs.sv
// ----------------------------------------------------------------------------
// socm_regs
// APB-style register file holding the segment end points and trim flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module socm_regs #(
  parameter int COORD_WIDTH = 32,
  localparam int DW = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AW = $clog2(8 * (DW / 8))
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [AW-1:0]                          paddr,
  input  wire logic [DW-1:0]                          pwdata,
  output logic      [DW-1:0]                          prdata,
  output logic                                        pready,
  output logic      [2:0][COORD_WIDTH-1:0]            p1,
  output logic      [2:0][COORD_WIDTH-1:0]            p2,
  output socm_pkg::trim_t                             trim
);
  import socm_pkg::*;

  localparam int LSB = $clog2(DW / 8);

  logic [COORD_WIDTH-1:0] start_x, start_y, start_z;
  logic [COORD_WIDTH-1:0] end_x, end_y, end_z;
  logic                   trim_start, trim_end;
  logic [IDX_W-1:0]       idx;
  logic                   wr;

  assign idx    = paddr[AW-1:LSB];
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      start_z    <= '0;
      end_x      <= '0;
      end_y      <= '0;
      end_z      <= '0;
      trim_start <= 1'b0;
      trim_end   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_START_X:    start_x    <= pwdata[COORD_WIDTH-1:0];
        REG_START_Y:    start_y    <= pwdata[COORD_WIDTH-1:0];
        REG_START_Z:    start_z    <= pwdata[COORD_WIDTH-1:0];
        REG_END_X:      end_x      <= pwdata[COORD_WIDTH-1:0];
        REG_END_Y:      end_y      <= pwdata[COORD_WIDTH-1:0];
        REG_END_Z:      end_z      <= pwdata[COORD_WIDTH-1:0];
        REG_TRIM_START: trim_start <= pwdata[0];
        REG_TRIM_END:   trim_end   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_X:    prdata = DW'(start_x);
      REG_START_Y:    prdata = DW'(start_y);
      REG_START_Z:    prdata = DW'(start_z);
      REG_END_X:      prdata = DW'(end_x);
      REG_END_Y:      prdata = DW'(end_y);
      REG_END_Z:      prdata = DW'(end_z);
      REG_TRIM_START: prdata = DW'(trim_start);
      REG_TRIM_END:   prdata = DW'(trim_end);
      default:        prdata = '0;
    endcase
  end

  assign p1   = {start_z, start_y, start_x};
  assign p2   = {end_z, end_y, end_x};
  assign trim = '{trim_start: trim_start, trim_end: trim_end};

endmodule

`default_nettype wire

// File: sv/socm_pipe.sv
// ----------------------------------------------------------------------------
// socm_pipe
// Four-stage datapath: differences, cross products, signs, child mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module socm_pipe #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [2:0][2:0][COORD_WIDTH-1:0]  bnd,
  input  wire logic [7:0]                        present,
  input  wire logic [2:0][COORD_WIDTH-1:0]       p1,
  input  wire logic [2:0][COORD_WIDTH-1:0]       p2,
  input  wire socm_pkg::trim_t                   trim,
  output logic                                   out_valid,
  output logic [7:0]                             out_mask
);
  import socm_pkg::*;

  localparam int D = COORD_WIDTH + 1;
  localparam int P = 2 * D;

  // stage 1: differences, trim decisions and start-point child
  logic signed [D-1:0] d_c  [NUM_AXES];
  logic signed [D-1:0] n_c  [NUM_AXES][NUM_PLANE];
  logic signed [D-1:0] pb_c [NUM_AXES][NUM_PLANE];
  logic                skip_c [NUM_AXES][NUM_PLANE];
  logic [7:0]          shit_c;

  logic signed [D-1:0] d_s1  [NUM_AXES];
  logic signed [D-1:0] n_s1  [NUM_AXES][NUM_PLANE];
  logic signed [D-1:0] pb_s1 [NUM_AXES][NUM_PLANE];
  logic                skip_s1 [NUM_AXES][NUM_PLANE];
  logic [7:0]          shit_s1, present_s1;
  logic                v1;

  always_comb begin
    logic signed [D:0] e;
    logic              neg, over, in_node;
    logic [2:0]        start_child;
    in_node     = 1'b1;
    start_child = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      d_c[k] = $signed({p2[k][COORD_WIDTH-1], p2[k]}) - $signed({p1[k][COORD_WIDTH-1], p1[k]});
      for (int b = 0; b < NUM_PLANE; b++) begin
        pb_c[k][b] = $signed({p1[k][COORD_WIDTH-1], p1[k]})
                   - $signed({bnd[b][k][COORD_WIDTH-1], bnd[b][k]});
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_PLANE; j++) begin
        n_c[i][j] = -pb_c[i][j];
        e    = $signed({n_c[i][j][D-1], n_c[i][j]}) - $signed({d_c[i][D-1], d_c[i]});
        neg  = (n_c[i][j] != '0) && (n_c[i][j][D-1] != d_c[i][D-1]);
        over = (e != '0) && (e[D] == d_c[i][D-1]);
        skip_c[i][j] = (d_c[i] == '0) || (neg && trim.trim_start) || (over && trim.trim_end);
      end
      // start point containment, lower plane and upper plane
      if (pb_c[i][0][D-1] || (pb_c[i][2] != '0 && !pb_c[i][2][D-1])) in_node = 1'b0;
      start_child[i] = (pb_c[i][1] != '0) && !pb_c[i][1][D-1];
    end
    shit_c = '0;
    if (trim.trim_start && trim.trim_end && in_node) shit_c[start_child] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    d_s1       <= d_c;
    n_s1       <= n_c;
    pb_s1      <= pb_c;
    skip_s1    <= skip_c;
    shit_s1    <= shit_c;
    present_s1 <= present;
  end

  // stage 2: cross products
  logic signed [P-1:0] xp_s2 [NUM_AXES][2][NUM_PLANE];
  logic signed [P-1:0] yp_s2 [NUM_AXES][NUM_PLANE][2];
  logic                dneg_s2 [NUM_AXES];
  logic                skip_s2 [NUM_AXES][NUM_PLANE];
  logic [7:0]          shit_s2, present_s2;
  logic                v2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    for (int i = 0; i < NUM_AXES; i++) begin
      dneg_s2[i] <= d_s1[i][D-1];
      for (int a = 0; a < 2; a++) begin
        for (int b = 0; b < NUM_PLANE; b++) begin
          xp_s2[i][a][b] <= pb_s1[(i + 1 + a) % 3][b] * d_s1[i];
        end
        for (int j = 0; j < NUM_PLANE; j++) begin
          yp_s2[i][j][a] <= d_s1[(i + 1 + a) % 3] * n_s1[i][j];
        end
      end
    end
    skip_s2    <= skip_s1;
    shit_s2    <= shit_s1;
    present_s2 <= present_s1;
  end

  // stage 3: sign of each plane-side test
  logic ge_s3 [NUM_AXES][NUM_PLANE][2][NUM_PLANE];
  logic le_s3 [NUM_AXES][NUM_PLANE][2][NUM_PLANE];
  logic skip_s3 [NUM_AXES][NUM_PLANE];
  logic [7:0] shit_s3, present_s3;
  logic v3;

  always_ff @(posedge clk) begin
    logic signed [P:0] s;
    logic              sp, sn;
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_PLANE; j++) begin
        for (int a = 0; a < 2; a++) begin
          for (int b = 0; b < NUM_PLANE; b++) begin
            s  = $signed({xp_s2[i][a][b][P-1], xp_s2[i][a][b]})
               + $signed({yp_s2[i][j][a][P-1], yp_s2[i][j][a]});
            sn = s[P];
            sp = !s[P] && (s != '0);
            // negative direction flips the sense
            ge_s3[i][j][a][b] <= dneg_s2[i] ? !sp : !sn;
            le_s3[i][j][a][b] <= dneg_s2[i] ? !sn : !sp;
          end
        end
      end
    end
    skip_s3    <= skip_s2;
    shit_s3    <= shit_s2;
    present_s3 <= present_s2;
  end

  // stage 4: quadrant selection and child mask
  logic [7:0] hit_c;

  always_comb begin
    logic [1:0] ok;
    logic [1:0] hbit;
    logic [2:0] base;
    hit_c = shit_s3;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_PLANE; j++) begin
        for (int a = 0; a < 2; a++) begin
          if (ge_s3[i][j][a][0] && le_s3[i][j][a][1]) begin
            ok[a] = 1'b1; hbit[a] = 1'b0;
          end else if (ge_s3[i][j][a][1] && le_s3[i][j][a][2]) begin
            ok[a] = 1'b1; hbit[a] = 1'b1;
          end else begin
            ok[a] = 1'b0; hbit[a] = 1'b0;
          end
        end
        base = '0;
        base[(i + 1) % 3] = hbit[0];
        base[(i + 2) % 3] = hbit[1];
        if (!skip_s3[i][j] && ok[0] && ok[1]) begin
          hit_c[base] = 1'b1;
          base[i] = 1'b1;
          hit_c[base] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v3;
    out_mask <= hit_c & present_s3;
  end

endmodule

`default_nettype wire

// File: sv/socm_checker.sv
// ----------------------------------------------------------------------------
// socm_checker
// Port-level checks on transaction latency, mask containment and register readiness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module socm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       psel,
  input wire logic       penable,
  input wire logic       pready,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] child_present,
  input wire logic       done,
  input wire logic [7:0] visit_mask
);

  // no result without a matching accepted transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & ~busy, 4))
    else $error("result without matching transaction");

  // every accepted transaction gives a result
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start & ~busy) |-> ##4 done)
    else $error("transaction lost in pipeline");

  // only existing children are reported
  a_mask_in_present: assert property (@(posedge clk) disable iff (rst)
    done |-> ((visit_mask & ~$past(child_present, 4)) == 8'h00))
    else $error("mask marks a missing child");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (psel & penable) |-> pready)
    else $error("register access stalled");

endmodule

bind segment_octree_child_mask socm_checker u_socm_checker (.*);

`default_nettype wire
